// ===== sv/sng_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, configuration and status types for the smoothed noise gate.
package sng_pkg;

   // Field and state widths
   localparam int SAMPLE_W   = 24;
   localparam int CHANNELS   = 2;
   localparam int CHAN_W     = 1;
   localparam int IGAIN_W    = 16;
   localparam int IGAIN_FRAC = 14;
   localparam int THRESH_W   = 23;
   localparam int COEF_W     = 24;
   localparam int FRAC_W     = 24;
   localparam int ENV_W      = 24;
   localparam int GAIN_W     = 25;
   localparam int STATE_W    = ENV_W + GAIN_W;

   // Shared multiplier: signed operands wide enough for every pass
   localparam int MUL_W  = GAIN_W + 1;
   localparam int PROD_W = 2 * MUL_W;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << FRAC_W;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INPUT_GAIN       = 3'd0,
      CSR_GATE_THRESHOLD   = 3'd1,
      CSR_ENVELOPE_RELEASE = 3'd2,
      CSR_GAIN_ATTACK      = 3'd3,
      CSR_GAIN_RELEASE     = 3'd4
   } sng_csr_idx_type;

   typedef struct packed {
      logic [IGAIN_W-1:0]  input_gain;
      logic [THRESH_W-1:0] gate_threshold;
      logic [COEF_W-1:0]   envelope_release;
      logic [COEF_W-1:0]   gain_attack;
      logic [COEF_W-1:0]   gain_release;
   } sng_cfg_type;

   localparam sng_cfg_type CFG_RESET = '{
      input_gain:       16'd16384,
      gate_threshold:   23'd83886,
      envelope_release: 24'd16770227,
      gain_attack:      24'd16603360,
      gain_release:     24'd16770227
   };

   // Core status seen by the top level
   typedef struct packed {
      logic busy;
      logic state_wr;
   } sng_status_type;

endpackage

// ===== sv/smoothed_noise_gate.sv =====
`timescale 1ns / 1ps
// Top level of the smoothed noise gate: register file, core and checks.
//
// Per-channel peak-envelope noise gate. Each request word is one signed 24-bit sample
// with its channel; each produces exactly one response word, in order. Each sample
// makes four passes through one shared 26x26 multiplier (input gain, envelope decay,
// gain smoothing, output gain); the clamped gain update and its write-back to the
// two-entry state memory come between the third and fourth passes. The next sample is
// taken in the cycle its predecessor's response is loaded, so samples do not overlap;
// a held response delays that load. State entries read as reset values until first
// written, so no clearing pass follows reset. Configuration registers are written
// through the csr_ port, which is always ready.
module smoothed_noise_gate import sng_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CHAN_W-1:0]          req_channel,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [CHAN_W-1:0]          rsp_channel_out,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   sng_cfg_type    cfg_ff, cfg_in;
   sng_status_type core_status;

   assign csr_ready = 1'b1;

   // Register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (sng_csr_idx_type'(csr_index))
            CSR_INPUT_GAIN:       cfg_in.input_gain       = csr_wdata[IGAIN_W-1:0];
            CSR_GATE_THRESHOLD:   cfg_in.gate_threshold   = csr_wdata[THRESH_W-1:0];
            CSR_ENVELOPE_RELEASE: cfg_in.envelope_release = csr_wdata[COEF_W-1:0];
            CSR_GAIN_ATTACK:      cfg_in.gain_attack      = csr_wdata[COEF_W-1:0];
            CSR_GAIN_RELEASE:     cfg_in.gain_release     = csr_wdata[COEF_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sng_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_channel_out (rsp_channel_out),
      .rsp_sample_out  (rsp_sample_out),
      .status          (core_status)
   );

   // One sample at a time: stall right after every accepted word
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a sample is in flight");

   // State write-back in the update state follows every accepted sample
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##3 core_status.state_wr)
      else $error("state write-back missing after accepted sample");

   // A response appears only while a sample was in flight
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(core_status.busy))
      else $error("response without a sample in flight");

   // No response word straight out of reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

// ===== sv/sng_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sng_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sng_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module sng_mul import sng_pkg::*; (
   input  logic                     clock,
   input  logic                     mul_en,
   input  logic signed [MUL_W-1:0]  mul_a,
   input  logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   // Load the product only on an issue cycle, hold it otherwise
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== sv/sng_core.sv =====
`timescale 1ns / 1ps
// Sequencer, per-channel state memory and output register of the noise gate.
module sng_core import sng_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  sng_cfg_type                cfg,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CHAN_W-1:0]          req_channel,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [CHAN_W-1:0]          rsp_channel_out,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output sng_status_type             status
);

   localparam int SAT_W = 40;
   localparam int SUM_W = 28;
   localparam logic signed [SUM_W-1:0] SUM_UNITY = SUM_W'(UNITY_GAIN);
   localparam logic signed [MUL_W-1:0] MUL_UNITY = MUL_W'(UNITY_GAIN);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENV,
      ST_GAIN,
      ST_UPDATE,
      ST_SCALE,
      ST_FIN
   } state_type;

   // Saturate a wide signed value to the sample range
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [SAT_W-1:0] x
   );
      logic [SAT_W-SAMPLE_W:0] top;
      logic signed [SAMPLE_W-1:0] res;
      top = x[SAT_W-1:SAMPLE_W-1];
      if ((&top) || !(|top)) begin
         res = x[SAMPLE_W-1:0];
      end else if (x[SAT_W-1]) begin
         res = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return res;
   endfunction

   state_type                  state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHANNELS-1:0]        valid_ff, valid_in;
   logic [CHAN_W-1:0]          ch_ff, ch_in;
   logic signed [SAMPLE_W-1:0] scaled_ff, scaled_in;
   logic [GAIN_W-1:0]          g_ff, g_in;
   logic [ENV_W-1:0]           env_new_ff, env_new_in;
   logic                       open_ff, open_in;
   logic [GAIN_W-1:0]          g_new_ff, g_new_in;
   logic [CHAN_W-1:0]          rsp_channel_ff, rsp_channel_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   logic                       accept;
   logic                       out_free;
   logic                       mul_en;
   logic signed [MUL_W-1:0]    mul_a;
   logic signed [MUL_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic [STATE_W-1:0]         rd_data;
   logic [STATE_W-1:0]         wr_data;
   logic                       wr_en;

   logic [ENV_W-1:0]           env_old;
   logic [GAIN_W-1:0]          g_old;
   logic signed [SAMPLE_W:0]   scaled_x;
   logic signed [SAMPLE_W:0]   scaled_neg;
   logic [ENV_W-1:0]           mag;
   logic [ENV_W-1:0]           decayed;
   logic [ENV_W-1:0]           env_max;
   logic                       open_now;
   logic [COEF_W-1:0]          coef;
   logic signed [MUL_W-1:0]    diff;
   logic signed [SUM_W-1:0]    step;
   logic signed [SUM_W-1:0]    sum;
   logic [GAIN_W-1:0]          g_clamped;
   logic signed [SAMPLE_W-1:0] scaled_now;
   logic signed [SAMPLE_W-1:0] out_now;

   // Handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_FIN) && out_free));
   assign accept    = req_valid && !req_stall;

   // Stored state; a never-written entry reads as the reset value
   assign env_old = valid_ff[ch_ff] ? rd_data[STATE_W-1 -: ENV_W] : '0;
   assign g_old   = valid_ff[ch_ff] ? rd_data[GAIN_W-1:0] : UNITY_GAIN;

   // Input gain and saturation
   assign scaled_now = sat_sample(SAT_W'(prod >>> IGAIN_FRAC));

   // Envelope: peak of magnitude and decayed envelope
   assign scaled_x   = {scaled_ff[SAMPLE_W-1], scaled_ff};
   assign scaled_neg = -scaled_x;
   assign mag        = scaled_ff[SAMPLE_W-1] ? scaled_neg[ENV_W-1:0] : scaled_ff[ENV_W-1:0];
   assign decayed    = prod[FRAC_W +: ENV_W];
   assign env_max    = (mag > decayed) ? mag : decayed;
   assign open_now   = env_max >= {1'b0, cfg.gate_threshold};
   assign coef       = (open_now && (g_ff < UNITY_GAIN)) ? cfg.gain_attack : cfg.gain_release;
   assign diff       = $signed({1'b0, g_ff}) - (open_now ? MUL_UNITY : '0);

   // One-pole gain update with clamp to [0, unity]
   assign step = SUM_W'(prod >>> FRAC_W);
   assign sum  = (open_ff ? SUM_UNITY : '0) + step;
   always_comb begin
      if (sum[SUM_W-1]) begin
         g_clamped = '0;
      end else if (sum > SUM_UNITY) begin
         g_clamped = UNITY_GAIN;
      end else begin
         g_clamped = sum[GAIN_W-1:0];
      end
   end

   // Gated output
   assign out_now = sat_sample(SAT_W'(prod >>> FRAC_W));

   // Multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_IDLE, ST_FIN: begin
            mul_a = {{(MUL_W-SAMPLE_W){req_sample_in[SAMPLE_W-1]}}, req_sample_in};
            mul_b = {{(MUL_W-IGAIN_W){1'b0}}, cfg.input_gain};
         end
         ST_ENV: begin
            mul_a = {{(MUL_W-ENV_W){1'b0}}, env_old};
            mul_b = {{(MUL_W-COEF_W){1'b0}}, cfg.envelope_release};
         end
         ST_GAIN: begin
            mul_a = {{(MUL_W-COEF_W){1'b0}}, coef};
            mul_b = diff;
         end
         ST_SCALE: begin
            mul_a = {{(MUL_W-SAMPLE_W){scaled_ff[SAMPLE_W-1]}}, scaled_ff};
            mul_b = {{(MUL_W-GAIN_W){1'b0}}, g_new_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_en = accept || (state_ff == ST_ENV) || (state_ff == ST_GAIN)
                   || (state_ff == ST_SCALE);

   assign wr_en   = (state_ff == ST_UPDATE);
   assign wr_data = {env_new_ff, g_clamped};

   // Next state and datapath registers
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      valid_in       = valid_ff;
      ch_in          = ch_ff;
      scaled_in      = scaled_ff;
      g_in           = g_ff;
      env_new_in     = env_new_ff;
      open_in        = open_ff;
      g_new_in       = g_new_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_sample_in  = rsp_sample_ff;

      // Drop the word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_in    = req_channel;
               state_in = ST_ENV;
            end
         end
         ST_ENV: begin
            scaled_in = scaled_now;
            g_in      = g_old;
            state_in  = ST_GAIN;
         end
         ST_GAIN: begin
            env_new_in = env_max;
            open_in    = open_now;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            g_new_in          = g_clamped;
            valid_in[ch_ff]   = 1'b1;
            state_in          = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_channel_in = ch_ff;
               rsp_sample_in  = out_now;
               if (accept) begin
                  ch_in    = req_channel;
                  state_in = ST_ENV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      ch_ff          <= ch_in;
      scaled_ff      <= scaled_in;
      g_ff           <= g_in;
      env_new_ff     <= env_new_in;
      open_ff        <= open_in;
      g_new_ff       <= g_new_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_sample_ff  <= rsp_sample_in;
   end

   sng_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod   (prod)
   );

   sng_ram #(
      .WIDTH (STATE_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ch_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_channel),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign status.busy     = (state_ff != ST_IDLE);
   assign status.state_wr = (state_ff == ST_UPDATE);

endmodule

// ===== tb/sng_checker.sv =====
`timescale 1ns / 1ps
// Checker for the smoothed noise gate: predicts every response word and compares it.
module sng_checker import sng_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [CHAN_W-1:0]          req_channel,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [CHAN_W-1:0]          rsp_channel_out,
   input  logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   output int                         pending,
   output int                         mismatches,
   output int                         words_checked,
   output int                         gate_opens,
   output int                         gate_closes
);

   typedef struct packed {
      logic [CHAN_W-1:0]          channel;
      logic signed [SAMPLE_W-1:0] sample;
   } gated_word_type;

   localparam longint UNITY     = longint'(UNITY_GAIN);
   localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
   // keep the log readable if the block is badly broken
   localparam int     PRINT_CAP = 200;

   sng_cfg_type       cfg;
   logic [ENV_W-1:0]  env_level  [CHANNELS];
   logic [GAIN_W-1:0] gain_level [CHANNELS];
   logic              gate_open  [CHANNELS];
   gated_word_type    gated_q    [$];
   gated_word_type    want;

   task automatic report(input string what);
      if (mismatches < PRINT_CAP)
         $display("[%0t] check: %s", $time, what);
      mismatches++;
   endtask

   function automatic longint clip_sample(input longint x);
      if (x > SAMPLE_HI)
         return SAMPLE_HI;
      if (x < SAMPLE_LO)
         return SAMPLE_LO;
      return x;
   endfunction

   // Advance one channel's envelope and gain, return the gated word
   function automatic gated_word_type gate_sample(input logic [CHAN_W-1:0] ch,
                                                  input logic signed [SAMPLE_W-1:0] smp);
      longint         scaled;
      longint         level;
      longint         decayed;
      longint         g;
      longint         target;
      longint         coef;
      gated_word_type w;
      scaled    = clip_sample((longint'(smp) * longint'(cfg.input_gain)) >>> IGAIN_FRAC);
      w.channel = ch;
      // a channel without state only gets the input gain
      if (int'(ch) >= CHANNELS) begin
         w.sample = SAMPLE_W'(scaled);
         return w;
      end
      level   = (scaled < 0) ? -scaled : scaled;
      decayed = (longint'(env_level[ch]) * longint'(cfg.envelope_release)) >>> FRAC_W;
      if (decayed > level)
         level = decayed;
      g      = longint'(gain_level[ch]);
      target = (level >= longint'(cfg.gate_threshold)) ? UNITY : 0;
      coef   = (target > g) ? longint'(cfg.gain_attack) : longint'(cfg.gain_release);
      g      = target + ((coef * (g - target)) >>> FRAC_W);
      if (g < 0)
         g = 0;
      if (g > UNITY)
         g = UNITY;
      // tally gate transitions for the summary
      if ((target != 0) != gate_open[ch]) begin
         if (target != 0)
            gate_opens++;
         else
            gate_closes++;
         gate_open[ch] = (target != 0);
      end
      env_level[ch]  = ENV_W'(level);
      gain_level[ch] = GAIN_W'(g);
      w.sample       = SAMPLE_W'(clip_sample((scaled * g) >>> FRAC_W));
      return w;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg = CFG_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            env_level[i]  = '0;
            gain_level[i] = UNITY_GAIN;
            gate_open[i]  = 1'b1;
         end
         gated_q.delete();
         pending <= 0;
      end else begin
         // track register writes, drop unknown indexes
         if (csr_valid && csr_ready) begin
            case (sng_csr_idx_type'(csr_index))
               CSR_INPUT_GAIN:       cfg.input_gain       = csr_wdata[IGAIN_W-1:0];
               CSR_GATE_THRESHOLD:   cfg.gate_threshold   = csr_wdata[THRESH_W-1:0];
               CSR_ENVELOPE_RELEASE: cfg.envelope_release = csr_wdata[COEF_W-1:0];
               CSR_GAIN_ATTACK:      cfg.gain_attack      = csr_wdata[COEF_W-1:0];
               CSR_GAIN_RELEASE:     cfg.gain_release     = csr_wdata[COEF_W-1:0];
               default: ;
            endcase
         end
         // compare each accepted response word with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (gated_q.size() == 0) begin
               report($sformatf("unexpected word ch %0d sample %0d",
                                rsp_channel_out, rsp_sample_out));
            end else begin
               want = gated_q.pop_front();
               words_checked++;
               if (rsp_channel_out !== want.channel)
                  report($sformatf("channel %0d, predicted %0d", rsp_channel_out,
                                   want.channel));
               if (rsp_sample_out !== want.sample)
                  report($sformatf("ch %0d sample %0d, predicted %0d", want.channel,
                                   rsp_sample_out, want.sample));
            end
         end
         // predict each accepted request word
         if (req_valid && !req_stall)
            gated_q.push_back(gate_sample(req_channel, req_sample_in));
         pending <= gated_q.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the smoothed noise gate: clock, reset, stimulus and verdict.
module tb_top import sng_pkg::*; ();

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int SEGMENTS      = 8;
   localparam int SEGMENT_WORDS = 75;

   localparam logic signed [SAMPLE_W-1:0] FULL_POS = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W - 1){1'b0}}};
   localparam logic [CSR_IDX_W-1:0]       CSR_SPARE_LO = CSR_IDX_W'(CSR_GAIN_RELEASE + 1);

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [CHAN_W-1:0]          req_channel = '0;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [CHAN_W-1:0]          rsp_channel_out;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   int pending;
   int mismatches;
   int words_checked;
   int gate_opens;
   int gate_closes;
   int send_gap_pct = 0;
   int stall_pct = 0;
   int cycles = 0;
   int settings_loaded = 0;

   smoothed_noise_gate u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_channel(req_channel), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_channel_out(rsp_channel_out), .rsp_sample_out(rsp_sample_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   sng_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_channel(req_channel), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_channel_out(rsp_channel_out), .rsp_sample_out(rsp_sample_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .mismatches(mismatches), .words_checked(words_checked),
      .gate_opens(gate_opens), .gate_closes(gate_closes)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end
         IDLE_SENDER: begin
            send_gap_pct = 45;
            stall_pct    = 0;
         end
         IDLE_RECEIVER: begin
            send_gap_pct = 0;
            stall_pct    = 45;
         end
         default: begin
            send_gap_pct = 14;
            stall_pct    = 14;
         end
      endcase
   endtask

   // Offer one word after a random gap and hold it until taken
   task automatic send_sample(input logic [CHAN_W-1:0] ch,
                              input logic signed [SAMPLE_W-1:0] smp);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_channel   <= ch;
      req_sample_in <= smp;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every response word is back
   task automatic finish_burst();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all registers, with junk in the unused data bits and one unknown index
   task automatic load_settings(input sng_cfg_type c);
      logic [CSR_IDX_W-1:0]  idx [0:5];
      logic [CSR_DATA_W-1:0] val [0:5];
      idx[0] = CSR_INPUT_GAIN;
      val[0] = CSR_DATA_W'($urandom);
      val[0][IGAIN_W-1:0] = c.input_gain;
      idx[1] = CSR_GATE_THRESHOLD;
      val[1] = CSR_DATA_W'($urandom);
      val[1][THRESH_W-1:0] = c.gate_threshold;
      idx[2] = CSR_SPARE_LO + CSR_IDX_W'($urandom_range(0, 2));
      val[2] = CSR_DATA_W'($urandom);
      idx[3] = CSR_ENVELOPE_RELEASE;
      val[3] = c.envelope_release;
      idx[4] = CSR_GAIN_ATTACK;
      val[4] = c.gain_attack;
      idx[5] = CSR_GAIN_RELEASE;
      val[5] = c.gain_release;
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // Reset values, all ones, all zeros, then random settings
   function automatic sng_cfg_type pick_settings(input int seg);
      sng_cfg_type c;
      case (seg)
         0: c = CFG_RESET;
         1: c = '1;
         2: c = '0;
         5: begin
            c.input_gain       = IGAIN_W'($urandom);
            c.gate_threshold   = THRESH_W'($urandom);
            c.envelope_release = COEF_W'($urandom);
            c.gain_attack      = COEF_W'($urandom);
            c.gain_release     = COEF_W'($urandom);
         end
         default: begin
            c.input_gain       = IGAIN_W'($urandom_range(4096, 49152));
            c.gate_threshold   = THRESH_W'($urandom_range(0, 1 << 20));
            c.envelope_release = COEF_W'((1 << COEF_W) - 1 - $urandom_range(0, 1 << 21));
            c.gain_attack      = COEF_W'($urandom);
            c.gain_release     = COEF_W'($urandom);
         end
      endcase
      return c;
   endfunction

   // Loud bursts open the gate, quiet ones let it close
   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit loud);
      int                         roll;
      logic signed [SAMPLE_W-1:0] mag;
      roll = $urandom_range(0, 99);
      if (roll < (loud ? 10 : 2)) begin
         case ($urandom_range(0, 3))
            0:       return FULL_POS;
            1:       return FULL_NEG;
            2:       return '0;
            default: return '1;
         endcase
      end
      if (roll < (loud ? 40 : 6))
         return SAMPLE_W'($urandom);
      if (loud)
         mag = SAMPLE_W'($urandom_range(1 << 18, (1 << 23) - 1));
      else
         mag = SAMPLE_W'($urandom_range(0, 1 << 12));
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   initial begin
      int seg;
      int n;
      bit loud;
      loud = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, quiet start closes the gate, then extremes
      set_idle(IDLE_NONE);
      send_sample(1'b0, '0);
      send_sample(1'b1, 24'sd1);
      send_sample(1'b0, FULL_POS);
      send_sample(1'b1, FULL_NEG);
      send_sample(1'b0, '1);
      send_sample(1'b1, '0);
      send_sample(1'b0, -24'sd83886);
      send_sample(1'b0, 24'sd83886);
      send_sample(1'b1, 24'sd83885);
      send_sample(1'b0, FULL_NEG);
      send_sample(1'b1, FULL_POS);
      send_sample(1'b0, 24'sh555555);
      send_sample(1'b1, 24'shAAAAAA);
      finish_burst();

      // directed: input gain overflow, zero threshold, instant smoothing
      load_settings('{input_gain: '1, gate_threshold: '0, envelope_release: '0,
                      gain_attack: '0, gain_release: '0});
      send_sample(1'b0, FULL_POS);
      send_sample(1'b1, FULL_NEG);
      send_sample(1'b0, '0);
      send_sample(1'b1, '1);
      send_sample(1'b0, 24'sd4096);
      send_sample(1'b1, -24'sd4096);
      send_sample(1'b0, 24'sd2097152);
      finish_burst();

      // random: one settings change and one idling mode per segment
      for (seg = 0; seg < SEGMENTS; seg++) begin
         load_settings(pick_settings(seg));
         set_idle(idle_mode_type'(seg % 4));
         for (n = 0; n < SEGMENT_WORDS; n++) begin
            if ($urandom_range(0, 29) == 0)
               loud = !loud;
            send_sample(CHAN_W'($urandom), pick_sample(loud));
         end
         finish_burst();
      end

      $display("summary: %0d words compared across %0d register settings",
               words_checked, settings_loaded);
      $display("summary: gate opened %0d times and closed %0d times", gate_opens,
               gate_closes);
      if (mismatches == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
sv/sng_pkg.sv
sv/sng_ram.sv
sv/sng_mul.sv
sv/sng_core.sv
sv/smoothed_noise_gate.sv
tb/sng_checker.sv
tb/tb_top.sv
